[rtl/core/gif_lzw_compressor_top_defines.svh]
// assertion macros for the gif lzw compressor
`ifndef GIF_LZW_COMPRESSOR_TOP_DEFINES_SVH
`define GIF_LZW_COMPRESSOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GLC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("glc check failed");
`define GLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("glc check failed");
`else
`define GLC_ASSERT_SAME(lbl, ante, cons)
`define GLC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/glc_pkg.sv]
// shared types and constants of the gif lzw compressor
package glc_pkg;
	localparam int HASH_DEPTH = 8192;
	localparam int MAX_CODES = 4096;
	localparam int MAX_WIDTH = 12;
	localparam int EPOCH_W = 8;
	localparam logic [3:0] MIN_CODE_RESET = 4'd8;
	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	// one dictionary entry, epoch tag marks it live for the current table
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [11:0] prefix;
		logic [7:0] sym;
		logic [11:0] code;
	} dict_entry_t;

	// one code handed to the bit packer
	typedef struct packed {
		logic [11:0] code;
		logic [3:0] width;
		logic fin;
	} pk_cmd_t;
endpackage

[rtl/core/glc_dict.sv]
// dictionary memory, one read and one write port, registered read data
module glc_dict #(
	parameter int AW = 13
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output glc_pkg::dict_entry_t rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input glc_pkg::dict_entry_t wr_data
);
	import glc_pkg::*;

	dict_entry_t mem_q [2**AW];
	dict_entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

[rtl/core/glc_packer.sv]
// packs variable width codes lsb first into bytes behind an output register
module glc_packer (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input glc_pkg::pk_cmd_t cmd,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // out_byte
	output logic m_tlast // last_byte
);
	import glc_pkg::*;

	logic [18:0] acc_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic fin_q;
	logic ob_valid_q;
	logic [7:0] ob_q;
	logic olast_q;
	logic load_ok;
	logic byte_load;

	assign cmd_ready = !busy_q;
	assign load_ok = !ob_valid_q || m_tready;
	assign byte_load = busy_q && load_ok && ((cnt_q >= 5'd8) || (fin_q && (cnt_q != 5'd0)));
	assign m_tvalid = ob_valid_q;
	assign m_tdata = ob_q;
	assign m_tlast = olast_q;

	// bit accumulator and byte emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			ob_valid_q <= 1'b0;
			ob_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (m_tready && !byte_load) begin
				ob_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (cmd_valid) begin
					acc_q <= acc_q | (19'(cmd.code) << cnt_q);
					cnt_q <= cnt_q + 5'(cmd.width);
					fin_q <= cmd.fin;
					busy_q <= 1'b1;
				end
			end else if (cnt_q >= 5'd8) begin
				if (load_ok) begin
					ob_q <= acc_q[7:0];
					olast_q <= fin_q && (cnt_q == 5'd8);
					ob_valid_q <= 1'b1;
					acc_q <= acc_q >> 8;
					cnt_q <= cnt_q - 5'd8;
				end
			end else if (fin_q && (cnt_q != 5'd0)) begin
				// flush of the partial byte at frame end
				if (load_ok) begin
					ob_q <= acc_q[7:0];
					olast_q <= 1'b1;
					ob_valid_q <= 1'b1;
					acc_q <= '0;
					cnt_q <= '0;
					busy_q <= 1'b0;
				end
			end else begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/core/glc_ctrl.sv]
// item sequencer: hashing, probing, dictionary update and code issue
module glc_ctrl #(
	parameter int AW = 13
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] min_code_size,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // pixel_index
	input logic s_tlast, // last_pixel
	output logic cmd_valid,
	input logic cmd_ready,
	output glc_pkg::pk_cmd_t cmd,
	output logic rd_en,
	output logic [AW-1:0] rd_addr,
	input glc_pkg::dict_entry_t rd_data,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output glc_pkg::dict_entry_t wr_data
);
	import glc_pkg::*;

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PUTC = 4'd2;
	localparam logic [3:0] S_HASH = 4'd3;
	localparam logic [3:0] S_RD = 4'd4;
	localparam logic [3:0] S_CMP = 4'd5;
	localparam logic [3:0] S_PUTP = 4'd6;
	localparam logic [3:0] S_UPD = 4'd7;
	localparam logic [3:0] S_FIN1 = 4'd8;
	localparam logic [3:0] S_FIN2 = 4'd9;

	localparam logic [12:0] CODE_LIMIT = 13'(MAX_CODES);
	localparam logic [3:0] WIDTH_LIMIT = 4'(MAX_WIDTH);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

	logic [3:0] state_q;
	logic [3:0] ret_q;
	logic [AW-1:0] clr_addr_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [11:0] prefix_q;
	logic [12:0] free_q;
	logic [3:0] cw_q;
	logic [3:0] fm_q;
	logic in_frame_q;
	logic [7:0] sym_q;
	logic last_q;
	logic [AW-1:0] slot_q;

	logic [3:0] eff_min;
	logic [3:0] fm_use;
	logic [7:0] sym_in;
	logic [31:0] hash_prod;
	logic [12:0] clear_code;
	logic [12:0] free_next;
	logic [12:0] cw_pow;
	logic entry_hit;
	logic entry_live;

	// clamp of the configured code size
	always_comb begin
		eff_min = min_code_size;
		if (min_code_size < 4'd2) begin
			eff_min = 4'd2;
		end else if (min_code_size > 4'd8) begin
			eff_min = 4'd8;
		end
	end

	assign fm_use = in_frame_q ? fm_q : eff_min;
	assign sym_in = s_tdata & ~(8'hFF << fm_use);
	assign hash_prod = {12'd0, prefix_q, sym_q} * HASH_MULT;
	assign clear_code = 13'd1 << fm_q;
	assign free_next = free_q + 13'd1;
	assign cw_pow = 13'd1 << cw_q;
	assign entry_live = (rd_data.epoch == epoch_q);
	assign entry_hit = entry_live && (rd_data.prefix == prefix_q) && (rd_data.sym == sym_q);

	assign s_tready = (state_q == S_IDLE);

	// memory ports
	always_comb begin
		rd_en = (state_q == S_RD);
		rd_addr = slot_q;
		wr_en = 1'b0;
		wr_addr = slot_q;
		wr_data.epoch = epoch_q;
		wr_data.prefix = prefix_q;
		wr_data.sym = sym_q;
		wr_data.code = free_q[11:0];
		if (state_q == S_CLR) begin
			wr_en = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if ((state_q == S_UPD) && (free_q < CODE_LIMIT)) begin
			wr_en = 1'b1;
		end
	end

	// code issue to the packer
	always_comb begin
		cmd_valid = 1'b0;
		cmd.code = prefix_q;
		cmd.width = cw_q;
		cmd.fin = 1'b0;
		case (state_q)
			S_PUTC: begin
				cmd_valid = 1'b1;
				cmd.code = clear_code[11:0];
			end
			S_PUTP, S_FIN1: begin
				cmd_valid = 1'b1;
			end
			S_UPD: begin
				cmd_valid = (free_q >= CODE_LIMIT);
				cmd.code = clear_code[11:0];
			end
			S_FIN2: begin
				cmd_valid = 1'b1;
				cmd.code = clear_code[11:0] + 12'd1;
				cmd.fin = 1'b1;
			end
			default: begin
				cmd_valid = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= S_IDLE;
			clr_addr_q <= '0;
			epoch_q <= '0;
			prefix_q <= '0;
			free_q <= 13'd258;
			cw_q <= 4'd9;
			fm_q <= MIN_CODE_RESET;
			in_frame_q <= 1'b0;
			sym_q <= '0;
			last_q <= 1'b0;
			slot_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						epoch_q <= EPOCH_FIRST;
						state_q <= ret_q;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						sym_q <= sym_in;
						last_q <= s_tlast;
						if (!in_frame_q) begin
							// frame start: latch code size, restart table
							fm_q <= eff_min;
							free_q <= (13'd1 << eff_min) + 13'd2;
							cw_q <= eff_min + 4'd1;
							in_frame_q <= 1'b1;
							if (epoch_q == EPOCH_LAST) begin
								ret_q <= S_PUTC;
								state_q <= S_CLR;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= S_PUTC;
							end
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_PUTC: begin
					if (cmd_ready) begin
						prefix_q <= 12'(sym_q);
						state_q <= last_q ? S_FIN1 : S_IDLE;
					end
				end
				S_HASH: begin
					slot_q <= hash_prod[7 +: AW];
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (entry_hit) begin
						prefix_q <= rd_data.code;
						state_q <= last_q ? S_FIN1 : S_IDLE;
					end else if (!entry_live) begin
						state_q <= S_PUTP;
					end else begin
						// linear probe to the next slot
						slot_q <= slot_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_PUTP: begin
					if (cmd_ready) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (free_q < CODE_LIMIT) begin
						free_q <= free_next;
						if ((free_next > cw_pow) && (cw_q < WIDTH_LIMIT)) begin
							cw_q <= cw_q + 4'd1;
						end
						prefix_q <= 12'(sym_q);
						state_q <= last_q ? S_FIN1 : S_IDLE;
					end else if (cmd_ready) begin
						// table full: clear code sent, table restarts
						prefix_q <= 12'(sym_q);
						free_q <= clear_code + 13'd2;
						cw_q <= fm_q + 4'd1;
						if (epoch_q == EPOCH_LAST) begin
							ret_q <= last_q ? S_FIN1 : S_IDLE;
							state_q <= S_CLR;
						end else begin
							epoch_q <= epoch_q + 1'b1;
							state_q <= last_q ? S_FIN1 : S_IDLE;
						end
					end
				end
				S_FIN1: begin
					if (cmd_ready) begin
						if ((free_q == cw_pow) && (cw_q < WIDTH_LIMIT)) begin
							cw_q <= cw_q + 4'd1;
						end
						state_q <= S_FIN2;
					end
				end
				S_FIN2: begin
					if (cmd_ready) begin
						in_frame_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/core/gif_lzw_compressor_top.sv]
// top level of the gif lzw compressor
//
// channel  | dir | fields
// s_axis   | in  | tdata = pixel_index, tlast = last_pixel
// m_axis   | out | tdata = out_byte, tlast = last_byte
// cfg      | in  | data = min_code_size
//
// a pixel at frame start issues the clear code; any other is hashed, read, compared and,
// on a miss, issued as prefix code with a dictionary update; extra probes repeat read
// and compare, and at frame end the last prefix and end codes are issued. each code
// issued waits while the packer still drains bytes of the one before. after reset and
// after every 255th table restart a clearing pass sweeps the memory; no pixel is taken
// meanwhile. a stalled output holds the packer, which in turn holds the sequencer.
`include "gif_lzw_compressor_top_defines.svh"
module gif_lzw_compressor_top #(
	parameter int HASH_DEPTH = glc_pkg::HASH_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // pixel_index
	input logic s_tlast, // last_pixel
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // out_byte
	output logic m_tlast, // last_byte
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_data // min_code_size
);
	import glc_pkg::*;

	localparam int AW = $clog2(HASH_DEPTH);

	logic [3:0] min_code_size_q;
	logic cmd_valid;
	logic cmd_ready;
	pk_cmd_t cmd;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	dict_entry_t rd_data;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	dict_entry_t wr_data;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= MIN_CODE_RESET;
		end else if (cfg_valid) begin
			min_code_size_q <= cfg_data;
		end
	end

	glc_ctrl #(.AW(AW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.min_code_size(min_code_size_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	glc_dict #(.AW(AW)) u_dict (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	glc_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// a pixel keeps the sequencer busy for at least the next cycle
	`GLC_ASSERT_NEXT(a_busy_after_pixel, s_tvalid && s_tready, !s_tready)
	// a code waiting for the packer stays offered
	`GLC_ASSERT_NEXT(a_cmd_held, cmd_valid && !cmd_ready, cmd_valid)
	// code widths stay in the gif range
	`GLC_ASSERT_SAME(a_cmd_width, cmd_valid, (cmd.width >= 4'd3) && (cmd.width <= 4'd12))
	// no dictionary write while a probe read is issued
	`GLC_ASSERT_SAME(a_port_excl, rd_en, !wr_en)
endmodule
